FILE: src/fifoqs_pkg.sv
// types and codes shared by the search queue block
// no dependencies

package fifoqs_pkg;

  // request codes carried on func
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN
  } state_t;

endpackage

FILE: src/fifoqs_ram.sv
// entry store of the search queue: one write port, one read port
// read data registered; no dependencies

module fifoqs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/fifo_queue_with_search.sv
// bounded fifo queue of signed words with a locate search
// depends on fifoqs_pkg and fifoqs_ram

// The queue keeps up to DEPTH words of WIDTH bits in a ring store (one
// synchronous ram with registered read data) with head and tail pointers and
// an entry count. Each input word carries a request: push, pop, peek,
// locate or clear; each request returns exactly one result word with a
// status, the popped or peeked value, the locate position (1-based from
// the head, 0 when nothing matches) and the occupancy after the request.
// One request is worked at a time. Push, clear, unused codes and
// requests that hit an empty queue register their result from the exec
// state, pop and peek first make one ram read of the head entry, and
// locate reads entries from the head until the first match, or through
// the whole occupancy when nothing matches; the scan reads one entry a
// cycle through the single ram read port. The queue is ready for the
// next request as soon as the result sits in the output register,
// even while that result still waits to be taken; a result is only
// registered once the output register is free. Values are stored and
// compared in their low WIDTH bits; out_value is the stored word
// sign-extended from WIDTH bits and cut to 32. No clearing pass is
// needed after reset: entries are only read once written.

module fifo_queue_with_search #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     func,
  input  logic signed [31:0]             in_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic signed [31:0]             out_value,
  output logic [$clog2(DEPTH+1)-1:0]     position,
  output logic [$clog2(DEPTH+1)-1:0]     occupancy
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  // queue state
  fifoqs_pkg::state_t state, state_next;
  fifoqs_pkg::func_t  op, op_next;
  logic [WIDTH-1:0]   val, val_next;
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;
  logic [CNT_W-1:0]   cnt, cnt_next;

  // locate scan: address being returned by the ram and its offset from head
  logic [AW-1:0]      scan_ptr, scan_ptr_next;
  logic [CNT_W-1:0]   scan_idx, scan_idx_next;

  // output register
  logic                out_valid_next;
  fifoqs_pkg::status_t res_status, res_status_next;
  logic [31:0]         res_value, res_value_next;
  logic [CNT_W-1:0]    res_pos, res_pos_next;
  logic [CNT_W-1:0]    res_occ, res_occ_next;

  // ram ports
  logic             wr_en;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [WIDTH-1:0] rd_data;

  logic             out_free;
  logic [63:0]      in_wide;
  logic [63:0]      rd_ext;
  logic             hit;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    nxt = (p == AW'(DEPTH-1)) ? '0 : p + AW'(1);
  endfunction

  fifoqs_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // incoming value zero-extended, then kept in its low WIDTH bits
  assign in_wide = {32'b0, in_value};
  // stored word sign-extended for the result
  assign rd_ext  = 64'($signed(rd_data));
  assign hit     = (rd_data == val);

  // the output register can take a new result this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == fifoqs_pkg::S_IDLE);

  always_comb begin
    state_next      = state;
    op_next         = op;
    val_next        = val;
    head_next       = head;
    tail_next       = tail;
    cnt_next        = cnt;
    scan_ptr_next   = scan_ptr;
    scan_idx_next   = scan_idx;
    out_valid_next  = out_valid && !out_ready;
    res_status_next = res_status;
    res_value_next  = res_value;
    res_pos_next    = res_pos;
    res_occ_next    = res_occ;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = head;

    case (state)
      fifoqs_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next    = fifoqs_pkg::func_t'(func);
          val_next   = in_wide[WIDTH-1:0];
          state_next = fifoqs_pkg::S_EXEC;
        end
      end

      fifoqs_pkg::S_EXEC: begin
        case (op)
          fifoqs_pkg::OP_PUSH: begin
            if (out_free) begin
              if (cnt == CNT_W'(DEPTH)) begin
                res_status_next = fifoqs_pkg::ST_FULL;
              end else begin
                wr_en           = 1'b1;
                tail_next       = nxt(tail);
                cnt_next        = cnt + CNT_W'(1);
                res_status_next = fifoqs_pkg::ST_OK;
              end
              out_valid_next = 1'b1;
              res_value_next = '0;
              res_pos_next   = '0;
              res_occ_next   = cnt_next;
              state_next     = fifoqs_pkg::S_IDLE;
            end
          end

          fifoqs_pkg::OP_POP, fifoqs_pkg::OP_PEEK, fifoqs_pkg::OP_LOCATE: begin
            if (cnt == '0) begin
              if (out_free) begin
                out_valid_next  = 1'b1;
                res_status_next = fifoqs_pkg::ST_EMPTY;
                res_value_next  = '0;
                res_pos_next    = '0;
                res_occ_next    = cnt;
                state_next      = fifoqs_pkg::S_IDLE;
              end
            end else begin
              // fetch the head entry
              rd_en         = 1'b1;
              rd_addr       = head;
              scan_ptr_next = head;
              scan_idx_next = '0;
              state_next    = (op == fifoqs_pkg::OP_LOCATE) ? fifoqs_pkg::S_SCAN
                                                            : fifoqs_pkg::S_READ;
            end
          end

          fifoqs_pkg::OP_CLEAR: begin
            if (out_free) begin
              head_next       = '0;
              tail_next       = '0;
              cnt_next        = '0;
              out_valid_next  = 1'b1;
              res_status_next = fifoqs_pkg::ST_OK;
              res_value_next  = '0;
              res_pos_next    = '0;
              res_occ_next    = '0;
              state_next      = fifoqs_pkg::S_IDLE;
            end
          end

          default: begin
            // unused codes: no change, plain ok result
            if (out_free) begin
              out_valid_next  = 1'b1;
              res_status_next = fifoqs_pkg::ST_OK;
              res_value_next  = '0;
              res_pos_next    = '0;
              res_occ_next    = cnt;
              state_next      = fifoqs_pkg::S_IDLE;
            end
          end
        endcase
      end

      fifoqs_pkg::S_READ: begin
        // head entry is on rd_data
        if (out_free) begin
          if (op == fifoqs_pkg::OP_POP) begin
            head_next = nxt(head);
            cnt_next  = cnt - CNT_W'(1);
          end
          out_valid_next  = 1'b1;
          res_status_next = fifoqs_pkg::ST_OK;
          res_value_next  = rd_ext[31:0];
          res_pos_next    = '0;
          res_occ_next    = cnt_next;
          state_next      = fifoqs_pkg::S_IDLE;
        end
      end

      fifoqs_pkg::S_SCAN: begin
        // rd_data holds the entry at offset scan_idx from head
        if (hit || (scan_idx + CNT_W'(1) == cnt)) begin
          if (out_free) begin
            out_valid_next  = 1'b1;
            res_status_next = fifoqs_pkg::ST_OK;
            res_value_next  = '0;
            res_pos_next    = hit ? scan_idx + CNT_W'(1) : '0;
            res_occ_next    = cnt;
            state_next      = fifoqs_pkg::S_IDLE;
          end
        end else begin
          rd_en         = 1'b1;
          rd_addr       = nxt(scan_ptr);
          scan_ptr_next = nxt(scan_ptr);
          scan_idx_next = scan_idx + CNT_W'(1);
        end
      end

      default: begin
        state_next = fifoqs_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fifoqs_pkg::S_IDLE;
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op         <= op_next;
    val        <= val_next;
    scan_ptr   <= scan_ptr_next;
    scan_idx   <= scan_idx_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    res_pos    <= res_pos_next;
    res_occ    <= res_occ_next;
  end

  assign status    = res_status;
  assign out_value = res_value;
  assign position  = res_pos;
  assign occupancy = res_occ;

  // count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // a push only writes the store when there is room
  a_wr_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cnt < CNT_W'(DEPTH)))
    else $error("store write on a full queue");

  // an empty error leaves the queue empty
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_status == fifoqs_pkg::ST_EMPTY) |-> (res_occ == '0))
    else $error("empty error with entries present");

  // a full error reports a full queue
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_status == fifoqs_pkg::ST_FULL) |-> (res_occ == CNT_W'(DEPTH)))
    else $error("full error with room left");

  // a match lies within the current occupancy
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_pos <= res_occ))
    else $error("locate position beyond occupancy");

endmodule
